[rtl/rmh_pkg.sv]
// Package for the running median block: shared widths, heap command type, state enums.
// No dependencies.
`default_nettype none
package rmh_pkg;

    localparam int DATA_W          = 32;
    localparam int MED_W           = 33;
    localparam int COUNT_W         = 11;
    localparam int DEF_CAPACITY    = 1024;
    localparam int DEF_SAMPLE_BITS = 32;

    typedef enum logic {
        OP_PUSH,
        OP_REPLACE
    } heap_op_t;

    typedef struct packed {
        logic                      start;
        heap_op_t                  op;
        logic signed [DATA_W-1:0]  value;
    } heap_cmd_t;

    typedef enum logic [2:0] {
        H_IDLE,
        H_UP_CMP,
        H_DN_L,
        H_DN_R,
        H_DN_CMP,
        H_FIN
    } heap_state_t;

    typedef enum logic [1:0] {
        T_IDLE,
        T_SWAP,
        T_PUSH,
        T_OUT
    } top_state_t;

    // true if a belongs above b
    function automatic logic above(input logic is_max,
                                   input logic signed [DATA_W-1:0] a,
                                   input logic signed [DATA_W-1:0] b);
        above = is_max ? (a > b) : (a < b);
    endfunction

endpackage
`default_nettype wire

[rtl/rmh_heap.sv]
// One binary heap held in a synchronous memory, with push and replace-top sequencers.
// Depends on rmh_pkg.
`default_nettype none
module rmh_heap #(
    parameter int DEPTH  = 512,
    parameter bit IS_MAX = 1'b1
) (
    input  wire                                    clk,
    input  wire                                    rst_n,
    input  wire rmh_pkg::heap_cmd_t                cmd,
    input  wire [$clog2(DEPTH+1)-1:0]              size,
    output logic                                   done,
    output logic signed [rmh_pkg::DATA_W-1:0]      top
);
    import rmh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int SW = $clog2(DEPTH+1);
    localparam int CW = AW + 2;

    logic signed [DATA_W-1:0] mem [DEPTH];

    heap_state_t              state_reg, state_next;
    logic [AW-1:0]            idx_reg, idx_next;
    logic signed [DATA_W-1:0] val_reg, val_next;
    logic [SW-1:0]            n_reg, n_next;
    logic signed [DATA_W-1:0] left_reg, left_next;
    logic signed [DATA_W-1:0] rd_data_reg;
    logic signed [DATA_W-1:0] top_reg;

    logic                     we, re;
    logic [AW-1:0]            wa, ra;
    logic signed [DATA_W-1:0] wd;

    logic [CW-1:0]            l_idx, r_idx, n_ext;
    logic [AW-1:0]            parent, start_parent;
    logic                     r_ok;
    logic signed [DATA_W-1:0] hc;
    logic [AW-1:0]            c_idx;

    always_comb
    begin
        l_idx        = {1'b0, idx_reg, 1'b1};
        r_idx        = l_idx + CW'(1);
        n_ext        = CW'(n_reg);
        r_ok         = r_idx < n_ext;
        parent       = (idx_reg - AW'(1)) >> 1;
        start_parent = AW'((CW'(size) - CW'(1)) >> 1);
        if (r_ok && above(IS_MAX, rd_data_reg, left_reg))
        begin
            hc    = rd_data_reg;
            c_idx = AW'(r_idx);
        end
        else
        begin
            hc    = left_reg;
            c_idx = AW'(l_idx);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        val_next   = val_reg;
        n_next     = n_reg;
        left_next  = left_reg;
        we = 1'b0;
        re = 1'b0;
        wa = idx_reg;
        ra = idx_reg;
        wd = val_reg;
        done = 1'b0;
        unique case (state_reg)
            H_IDLE:
            begin
                if (cmd.start)
                begin
                    val_next = cmd.value;
                    n_next   = size;
                    if (cmd.op == OP_REPLACE || size == '0)
                    begin
                        idx_next   = '0;
                        state_next = (cmd.op == OP_REPLACE) ? H_DN_L : H_FIN;
                    end
                    else
                    begin
                        // append at the end, fetch its parent
                        idx_next   = AW'(size);
                        re         = 1'b1;
                        ra         = start_parent;
                        state_next = H_UP_CMP;
                    end
                end
            end
            H_UP_CMP:
            begin
                if (above(IS_MAX, val_reg, rd_data_reg))
                begin
                    we       = 1'b1;
                    wd       = rd_data_reg;
                    idx_next = parent;
                    if (parent == '0)
                        state_next = H_FIN;
                    else
                    begin
                        re = 1'b1;
                        ra = (parent - AW'(1)) >> 1;
                    end
                end
                else
                    state_next = H_FIN;
            end
            H_DN_L:
            begin
                if (l_idx >= n_ext)
                    state_next = H_FIN;
                else
                begin
                    re         = 1'b1;
                    ra         = AW'(l_idx);
                    state_next = H_DN_R;
                end
            end
            H_DN_R:
            begin
                left_next = rd_data_reg;
                re        = r_ok;
                ra        = AW'(r_idx);
                state_next = H_DN_CMP;
            end
            H_DN_CMP:
            begin
                if (above(IS_MAX, hc, val_reg))
                begin
                    we         = 1'b1;
                    wd         = hc;
                    idx_next   = c_idx;
                    state_next = H_DN_L;
                end
                else
                    state_next = H_FIN;
            end
            H_FIN:
            begin
                we         = 1'b1;
                done       = 1'b1;
                state_next = H_IDLE;
            end
            default: state_next = H_IDLE;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (we)
            mem[wa] <= wd;
        if (re)
            rd_data_reg <= mem[ra];
        if (we && wa == '0)
            top_reg <= wd;
        val_reg  <= val_next;
        n_reg    <= n_next;
        left_reg <= left_next;
        idx_reg  <= idx_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= H_IDLE;
        else
            state_reg <= state_next;
    end

    assign top = top_reg;

endmodule
`default_nettype wire

[rtl/running_median_two_heaps.sv]
// Running median over two heaps: top level with insert sequencer and output register.
// Depends on rmh_pkg and rmh_heap.
//
// Usage:
//   Input channel (in_valid/in_ready, sample) takes one beat per sample; only the low
//   SAMPLE_BITS bits are used, as two's complement. Output channel (out_valid/out_ready)
//   gives one beat per input beat: median_doubled (twice the median, LSB is the half),
//   sample_count after the insert, and overflow when the store was full and the
//   sample was dropped.
//   Sequencing: an insert runs a possible replace-top sift-down on one heap (states
//   H_DN_L, H_DN_R and H_DN_CMP per level) and then a sift-up push on the other
//   (H_UP_CMP per level), plus the top-level control states; the steps per level are set
//   by the single read port of each heap memory. A dropped sample skips both heaps.
//   One item is in work at a time; in_ready is high only while idle.
//   The finished result sits in an output register; if the receiver stalls the block
//   holds the next result until the register drains, and the input stays blocked.
//   Reset clears both heap sizes; heap memories need no clearing since no entry is
//   read beyond the current size.
`default_nettype none
module running_median_two_heaps #(
    parameter int CAPACITY    = rmh_pkg::DEF_CAPACITY,
    parameter int SAMPLE_BITS = rmh_pkg::DEF_SAMPLE_BITS
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_ready,
    input  wire [rmh_pkg::DATA_W-1:0]            sample,
    output logic                                 out_valid,
    input  wire                                  out_ready,
    output logic [rmh_pkg::MED_W-1:0]            median_doubled,
    output logic [rmh_pkg::COUNT_W-1:0]          sample_count,
    output logic                                 overflow
);
    import rmh_pkg::*;

    localparam int LOWER_DEPTH = (CAPACITY + 1) / 2;
    localparam int UPPER_DEPTH = CAPACITY / 2;
    localparam int LSW = $clog2(LOWER_DEPTH + 1);
    localparam int USW = $clog2(UPPER_DEPTH + 1);
    localparam int TW  = $clog2(CAPACITY + 1);

    top_state_t               state_reg, state_next;
    logic [LSW-1:0]           lsize_reg, lsize_next;
    logic [USW-1:0]           usize_reg, usize_next;
    logic signed [DATA_W-1:0] s_reg, s_next;
    logic                     grow_lower_reg, grow_lower_next;
    logic                     ovf_reg, ovf_next;
    logic                     out_valid_reg, out_valid_next;
    logic [MED_W-1:0]         med_reg, med_next;
    logic [COUNT_W-1:0]       cnt_reg, cnt_next;
    logic                     oflag_reg, oflag_next;

    heap_cmd_t                lcmd, ucmd;
    logic                     ldone, udone;
    logic signed [DATA_W-1:0] ltop, utop;

    logic signed [DATA_W-1:0] s_in;
    logic [TW-1:0]            total;
    logic signed [MED_W-1:0]  med_calc;

    assign s_in  = DATA_W'($signed(sample[SAMPLE_BITS-1:0]));
    assign total = TW'(lsize_reg) + TW'(usize_reg);

    // Twice the median from the heap tops; sums at 33 bits never wrap.
    always_comb
    begin
        if (lsize_reg == '0)
            med_calc = '0;
        else if (TW'(lsize_reg) > TW'(usize_reg))
            med_calc = MED_W'(ltop) + MED_W'(ltop);
        else
            med_calc = MED_W'(ltop) + MED_W'(utop);
    end

    always_comb
    begin
        state_next      = state_reg;
        lsize_next      = lsize_reg;
        usize_next      = usize_reg;
        s_next          = s_reg;
        grow_lower_next = grow_lower_reg;
        ovf_next        = ovf_reg;
        out_valid_next  = out_valid_reg;
        med_next        = med_reg;
        cnt_next        = cnt_reg;
        oflag_next      = oflag_reg;
        lcmd            = '{start: 1'b0, op: OP_PUSH, value: s_reg};
        ucmd            = '{start: 1'b0, op: OP_PUSH, value: s_reg};
        in_ready        = (state_reg == T_IDLE);

        // drain the output register
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            T_IDLE:
            begin
                if (in_valid)
                begin
                    ovf_next        = 1'b0;
                    s_next          = s_in;
                    grow_lower_next = (TW'(lsize_reg) == TW'(usize_reg));
                    if (total >= TW'(CAPACITY))
                    begin
                        // store full: drop the sample
                        ovf_next   = 1'b1;
                        state_next = T_OUT;
                    end
                    else if (TW'(lsize_reg) == TW'(usize_reg))
                    begin
                        if (usize_reg != '0 && s_in > utop)
                        begin
                            // swap through the upper top, old top goes down
                            ucmd       = '{start: 1'b1, op: OP_REPLACE, value: s_in};
                            s_next     = utop;
                            state_next = T_SWAP;
                        end
                        else
                        begin
                            lcmd       = '{start: 1'b1, op: OP_PUSH, value: s_in};
                            state_next = T_PUSH;
                        end
                    end
                    else
                    begin
                        if (s_in < ltop)
                        begin
                            lcmd       = '{start: 1'b1, op: OP_REPLACE, value: s_in};
                            s_next     = ltop;
                            state_next = T_SWAP;
                        end
                        else
                        begin
                            ucmd       = '{start: 1'b1, op: OP_PUSH, value: s_in};
                            state_next = T_PUSH;
                        end
                    end
                end
            end
            T_SWAP:
            begin
                if (grow_lower_reg && udone)
                begin
                    lcmd       = '{start: 1'b1, op: OP_PUSH, value: s_reg};
                    state_next = T_PUSH;
                end
                else if (!grow_lower_reg && ldone)
                begin
                    ucmd       = '{start: 1'b1, op: OP_PUSH, value: s_reg};
                    state_next = T_PUSH;
                end
            end
            T_PUSH:
            begin
                if (grow_lower_reg && ldone)
                begin
                    lsize_next = lsize_reg + LSW'(1);
                    state_next = T_OUT;
                end
                else if (!grow_lower_reg && udone)
                begin
                    usize_next = usize_reg + USW'(1);
                    state_next = T_OUT;
                end
            end
            T_OUT:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    med_next       = med_calc;
                    cnt_next       = COUNT_W'(total);
                    oflag_next     = ovf_reg;
                    state_next     = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    rmh_heap #(
        .DEPTH  (LOWER_DEPTH),
        .IS_MAX (1'b1)
    ) u_lower (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (lcmd),
        .size  (lsize_reg),
        .done  (ldone),
        .top   (ltop)
    );

    rmh_heap #(
        .DEPTH  (UPPER_DEPTH),
        .IS_MAX (1'b0)
    ) u_upper (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (ucmd),
        .size  (usize_reg),
        .done  (udone),
        .top   (utop)
    );

    always_ff @(posedge clk)
    begin
        s_reg          <= s_next;
        grow_lower_reg <= grow_lower_next;
        ovf_reg        <= ovf_next;
        med_reg        <= med_next;
        cnt_reg        <= cnt_next;
        oflag_reg      <= oflag_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            lsize_reg     <= '0;
            usize_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            lsize_reg     <= lsize_next;
            usize_reg     <= usize_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign median_doubled = med_reg;
    assign sample_count   = cnt_reg;
    assign overflow       = oflag_reg;

`ifndef SYNTHESIS
    // lower heap holds as many as the upper heap or one more
    a_balance: assert property (@(posedge clk) disable iff (!rst_n)
        (TW'(lsize_reg) == TW'(usize_reg)) || (TW'(lsize_reg) == TW'(usize_reg) + TW'(1)))
        else $error("heap sizes out of balance");

    // one item at a time: no beat right after an accepted one
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second beat accepted while busy");

    // a dropped sample only when the store is full
    a_drop_full: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == T_OUT && ovf_reg) |-> (total == TW'(CAPACITY)))
        else $error("overflow with room left");

    // heaps never run a command at the same time
    a_one_heap: assert property (@(posedge clk) disable iff (!rst_n)
        !(lcmd.start && ucmd.start))
        else $error("both heaps started together");
`endif

endmodule
`default_nettype wire
